>>> rtl/abkf_pkg.sv
`timescale 1ns / 1ps
package abkf_pkg;

    localparam int WORD_W    = 32;
    localparam int CFG_W     = 31;
    localparam int CFG_IDX_W = 2;
    localparam int FRAC_COV  = 24;
    localparam int NUM_W     = WORD_W + FRAC_COV;
    localparam int DEN_W     = WORD_W + 1;
    localparam int CNT_W     = $clog2(NUM_W + 1);
    localparam int PC_W      = 4;

    localparam logic [CFG_IDX_W-1:0] REG_STEP_TIME   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ANGLE_NOISE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BIAS_NOISE  = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MEAS_NOISE  = 2'd3;

    localparam logic [CFG_W-1:0] RST_STEP_TIME   = 31'd83886;
    localparam logic [CFG_W-1:0] RST_ANGLE_NOISE = 31'd16777;
    localparam logic [CFG_W-1:0] RST_BIAS_NOISE  = 31'd83886;
    localparam logic [CFG_W-1:0] RST_MEAS_NOISE  = 31'd8388608;
    localparam logic [WORD_W-1:0] ONE_COV        = 32'd16777216;

    localparam logic signed [63:0] W_MAX = (64'sd1 <<< (WORD_W - 1)) - 64'sd1;
    localparam logic signed [63:0] W_MIN = -W_MAX - 64'sd1;
    localparam logic signed [63:0] RND_HALF = 64'sd1 <<< (FRAC_COV - 1);

    typedef enum logic [4:0] {
        OP_NOP, OP_LOAD, OP_M_RATE, OP_W_ANGLE, OP_ERR, OP_PDOT, OP_M_PDOT, OP_W_AA,
        OP_M_BB, OP_W_ABBA, OP_M_QB, OP_W_BB, OP_DIV_START, OP_DIV_STEP, OP_GAIN,
        OP_M_K0T0, OP_W_AA2, OP_M_K0T1, OP_W_AB2, OP_M_K1T0, OP_W_BA2, OP_M_K1T1,
        OP_W_BB2, OP_M_K0E, OP_W_ANG2, OP_M_K1E, OP_W_BIAS, OP_RATE
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic div_done;
    } t_stat;

    typedef struct packed {
        logic [WORD_W-1:0] val;
        logic              ovf;
    } t_sat;

    localparam logic [PC_W-1:0] PRE_LAST  = 4'd11;
    localparam logic [PC_W-1:0] POST_LAST = 4'd13;

    function automatic t_sat sat_w(input logic signed [63:0] v);
        t_sat r;
        if (v > W_MAX) begin
            r.val = W_MAX[WORD_W-1:0];
            r.ovf = 1'b1;
        end else if (v < W_MIN) begin
            r.val = W_MIN[WORD_W-1:0];
            r.ovf = 1'b1;
        end else begin
            r.val = v[WORD_W-1:0];
            r.ovf = 1'b0;
        end
        return r;
    endfunction

    function automatic t_op pre_op(input logic [PC_W-1:0] pc);
        t_op r;
        case (pc)
            4'd0:    r = OP_LOAD;
            4'd1:    r = OP_M_RATE;
            4'd2:    r = OP_W_ANGLE;
            4'd3:    r = OP_ERR;
            4'd4:    r = OP_PDOT;
            4'd5:    r = OP_M_PDOT;
            4'd6:    r = OP_W_AA;
            4'd7:    r = OP_M_BB;
            4'd8:    r = OP_W_ABBA;
            4'd9:    r = OP_M_QB;
            4'd10:   r = OP_W_BB;
            4'd11:   r = OP_DIV_START;
            default: r = OP_NOP;
        endcase
        return r;
    endfunction

    function automatic t_op post_op(input logic [PC_W-1:0] pc);
        t_op r;
        case (pc)
            4'd0:    r = OP_GAIN;
            4'd1:    r = OP_M_K0T0;
            4'd2:    r = OP_W_AA2;
            4'd3:    r = OP_M_K0T1;
            4'd4:    r = OP_W_AB2;
            4'd5:    r = OP_M_K1T0;
            4'd6:    r = OP_W_BA2;
            4'd7:    r = OP_M_K1T1;
            4'd8:    r = OP_W_BB2;
            4'd9:    r = OP_M_K0E;
            4'd10:   r = OP_W_ANG2;
            4'd11:   r = OP_M_K1E;
            4'd12:   r = OP_W_BIAS;
            4'd13:   r = OP_RATE;
            default: r = OP_NOP;
        endcase
        return r;
    endfunction

endpackage

>>> rtl/abkf_ctrl.sv
`timescale 1ns / 1ps
module abkf_ctrl
    import abkf_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_stall,
    output logic  o_out_valid,
    input  logic  i_out_stall,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_PRE, S_DIV, S_POST, S_OUT} t_state;

    t_state          r_state;
    logic [PC_W-1:0] r_pc;
    logic            r_out_valid;
    logic            w_out_free;

    assign w_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd.op       = OP_NOP;
        o_cmd.load_out = 1'b0;
        case (r_state)
            S_IDLE:  o_cmd.op = i_in_valid ? OP_LOAD : OP_NOP;
            S_PRE:   o_cmd.op = pre_op(r_pc);
            S_DIV:   o_cmd.op = i_stat.div_done ? OP_NOP : OP_DIV_STEP;
            S_POST:  o_cmd.op = post_op(r_pc);
            S_OUT:   o_cmd.load_out = w_out_free;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_pc        <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (r_out_valid && !i_out_stall && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (i_in_valid) begin
                        r_pc    <= 4'd1;
                        r_state <= S_PRE;
                    end
                end
                S_PRE: begin
                    if (r_pc == PRE_LAST) begin
                        r_state <= S_DIV;
                    end
                    r_pc <= r_pc + 4'd1;
                end
                S_DIV: begin
                    if (i_stat.div_done) begin
                        r_pc    <= '0;
                        r_state <= S_POST;
                    end
                end
                S_POST: begin
                    if (r_pc == POST_LAST) begin
                        r_state <= S_OUT;
                    end
                    r_pc <= r_pc + 4'd1;
                end
                S_OUT: begin
                    if (w_out_free) begin
                        r_out_valid <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule

>>> rtl/abkf_dp.sv
`timescale 1ns / 1ps
module abkf_dp
    import abkf_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_stat             o_stat,
    input  logic              i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]  i_cfg_data,
    input  logic [WORD_W-1:0] i_angle_meas,
    input  logic [WORD_W-1:0] i_rate_meas,
    output logic [WORD_W-1:0] o_angle_out,
    output logic [WORD_W-1:0] o_rate_out,
    output logic [WORD_W-1:0] o_bias_out,
    output logic              o_saturated
);

    logic [CFG_W-1:0] r_dt, r_qa, r_qb, r_rm;
    logic signed [WORD_W-1:0] r_angle, r_bias, r_aa, r_ab, r_ba, r_bb;
    logic signed [WORD_W-1:0] r_meas, r_gyro, r_rate, r_err, r_tmp, r_t0, r_t1, r_k0, r_k1;
    logic signed [63:0] r_prod;
    logic               r_flag;
    logic [WORD_W-1:0]  r_o_angle, r_o_rate, r_o_bias;
    logic               r_o_sat;

    logic [DEN_W:0]     r_rem0, r_rem1;
    logic [NUM_W-1:0]   r_q0, r_q1;
    logic [DEN_W-1:0]   r_den;
    logic               r_neg0, r_neg1, r_zero;
    logic [CNT_W-1:0]   r_cnt;

    logic signed [WORD_W-1:0] w_ma, w_mb, w_dts;
    logic signed [63:0]       w_rnd, w_base, w_acc, w_acc2;
    logic                     w_sub;
    t_sat                     w_s, w_s2, w_srate, w_serr, w_spdot, w_sk0, w_sk1, w_srate_in;
    logic signed [DEN_W:0]    w_e;
    logic [DEN_W:0]           w_emag;
    logic [WORD_W-1:0]        w_aa_mag, w_ba_mag;
    logic [DEN_W:0]           w_sh0, w_sh1, w_tr0, w_tr1;
    logic signed [NUM_W+1:0]  w_qs0, w_qs1;

    assign w_dts = $signed({1'b0, r_dt});
    assign o_stat.div_done = (r_cnt == '0);

    always_comb begin
        case (i_cmd.op)
            OP_M_RATE: begin w_ma = r_rate; w_mb = w_dts; end
            OP_M_PDOT: begin w_ma = r_tmp;  w_mb = w_dts; end
            OP_M_BB:   begin w_ma = r_bb;   w_mb = w_dts; end
            OP_M_QB:   begin w_ma = $signed({1'b0, r_qb}); w_mb = w_dts; end
            OP_M_K0T0: begin w_ma = r_k0;   w_mb = r_t0; end
            OP_M_K0T1: begin w_ma = r_k0;   w_mb = r_t1; end
            OP_M_K1T0: begin w_ma = r_k1;   w_mb = r_t0; end
            OP_M_K1T1: begin w_ma = r_k1;   w_mb = r_t1; end
            OP_M_K0E:  begin w_ma = r_k0;   w_mb = r_err; end
            OP_M_K1E:  begin w_ma = r_k1;   w_mb = r_err; end
            default:   begin w_ma = r_k1;   w_mb = r_err; end
        endcase
    end

    always_comb begin
        w_sub = 1'b0;
        case (i_cmd.op)
            OP_W_ANGLE, OP_W_ANG2: w_base = 64'(r_angle);
            OP_W_AA:               w_base = 64'(r_aa);
            OP_W_BB:               w_base = 64'(r_bb);
            OP_W_ABBA: begin w_base = 64'(r_ab); w_sub = 1'b1; end
            OP_W_AA2:  begin w_base = 64'(r_aa); w_sub = 1'b1; end
            OP_W_AB2:  begin w_base = 64'(r_ab); w_sub = 1'b1; end
            OP_W_BA2:  begin w_base = 64'(r_ba); w_sub = 1'b1; end
            OP_W_BB2:  begin w_base = 64'(r_bb); w_sub = 1'b1; end
            OP_W_BIAS:             w_base = 64'(r_bias);
            default:               w_base = 64'(r_bias);
        endcase
    end

    assign w_rnd  = (r_prod + RND_HALF) >>> FRAC_COV;
    assign w_acc  = w_sub ? (w_base - w_rnd) : (w_base + w_rnd);
    assign w_acc2 = 64'(r_ba) - w_rnd;
    assign w_s    = sat_w(w_acc);
    assign w_s2   = sat_w(w_acc2);
    assign w_srate_in = sat_w(64'($signed(i_rate_meas)) - 64'(r_bias));
    assign w_srate = sat_w(64'(r_gyro) - 64'(r_bias));
    assign w_serr  = sat_w(64'(r_meas) - 64'(r_angle));
    assign w_spdot = sat_w(64'($signed({1'b0, r_qa})) - 64'(r_ab) - 64'(r_ba));

    assign w_e      = $signed({2'b00, r_rm}) + (DEN_W+1)'(r_aa);
    assign w_emag   = w_e[DEN_W] ? (DEN_W+1)'(-w_e) : w_e;
    assign w_aa_mag = r_aa[WORD_W-1] ? WORD_W'(-r_aa) : r_aa;
    assign w_ba_mag = r_ba[WORD_W-1] ? WORD_W'(-r_ba) : r_ba;

    assign w_sh0 = {r_rem0[DEN_W-1:0], r_q0[NUM_W-1]};
    assign w_sh1 = {r_rem1[DEN_W-1:0], r_q1[NUM_W-1]};
    assign w_tr0 = w_sh0 - {1'b0, r_den};
    assign w_tr1 = w_sh1 - {1'b0, r_den};

    assign w_qs0 = r_neg0 ? -$signed({2'b00, r_q0}) : $signed({2'b00, r_q0});
    assign w_qs1 = r_neg1 ? -$signed({2'b00, r_q1}) : $signed({2'b00, r_q1});
    assign w_sk0 = sat_w(64'(w_qs0));
    assign w_sk1 = sat_w(64'(w_qs1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dt    <= RST_STEP_TIME;
            r_qa    <= RST_ANGLE_NOISE;
            r_qb    <= RST_BIAS_NOISE;
            r_rm    <= RST_MEAS_NOISE;
            r_angle <= '0;
            r_bias  <= '0;
            r_aa    <= ONE_COV;
            r_ab    <= '0;
            r_ba    <= '0;
            r_bb    <= ONE_COV;
            r_cnt   <= '0;
            r_zero  <= 1'b0;
            r_flag  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_STEP_TIME:   r_dt <= i_cfg_data;
                    REG_ANGLE_NOISE: r_qa <= i_cfg_data;
                    REG_BIAS_NOISE:  r_qb <= i_cfg_data;
                    REG_MEAS_NOISE:  r_rm <= i_cfg_data;
                    default:         r_dt <= r_dt;
                endcase
            end
            r_prod <= w_ma * w_mb;
            case (i_cmd.op)
                OP_LOAD: begin
                    r_meas <= i_angle_meas;
                    r_gyro <= i_rate_meas;
                    r_rate <= w_srate_in.val;
                    r_flag <= w_srate_in.ovf;
                end
                OP_W_ANGLE, OP_W_ANG2: begin
                    r_angle <= w_s.val;
                    r_flag  <= r_flag | w_s.ovf;
                end
                OP_ERR: begin
                    r_err  <= w_serr.val;
                    r_flag <= r_flag | w_serr.ovf;
                end
                OP_PDOT: begin
                    r_tmp  <= w_spdot.val;
                    r_flag <= r_flag | w_spdot.ovf;
                end
                OP_W_AA, OP_W_AA2: begin
                    r_aa   <= w_s.val;
                    r_flag <= r_flag | w_s.ovf;
                end
                OP_W_ABBA: begin
                    r_ab   <= w_s.val;
                    r_ba   <= w_s2.val;
                    r_flag <= r_flag | w_s.ovf | w_s2.ovf;
                end
                OP_W_BB, OP_W_BB2: begin
                    r_bb   <= w_s.val;
                    r_flag <= r_flag | w_s.ovf;
                end
                OP_W_AB2: begin
                    r_ab   <= w_s.val;
                    r_flag <= r_flag | w_s.ovf;
                end
                OP_W_BA2: begin
                    r_ba   <= w_s.val;
                    r_flag <= r_flag | w_s.ovf;
                end
                OP_W_BIAS: begin
                    r_bias <= w_s.val;
                    r_flag <= r_flag | w_s.ovf;
                end
                OP_DIV_START: begin
                    r_t0   <= r_aa;
                    r_t1   <= r_ab;
                    r_den  <= w_emag[DEN_W-1:0];
                    r_rem0 <= '0;
                    r_rem1 <= '0;
                    r_q0   <= {w_aa_mag, FRAC_COV'(0)};
                    r_q1   <= {w_ba_mag, FRAC_COV'(0)};
                    r_neg0 <= r_aa[WORD_W-1] ^ w_e[DEN_W];
                    r_neg1 <= r_ba[WORD_W-1] ^ w_e[DEN_W];
                    r_zero <= (w_e == '0);
                    r_cnt  <= (w_e == '0) ? '0 : CNT_W'(NUM_W);
                    r_flag <= r_flag | (w_e == '0);
                end
                OP_DIV_STEP: begin
                    r_rem0 <= w_tr0[DEN_W] ? w_sh0 : w_tr0;
                    r_rem1 <= w_tr1[DEN_W] ? w_sh1 : w_tr1;
                    r_q0   <= {r_q0[NUM_W-2:0], !w_tr0[DEN_W]};
                    r_q1   <= {r_q1[NUM_W-2:0], !w_tr1[DEN_W]};
                    r_cnt  <= r_cnt - CNT_W'(1);
                end
                OP_GAIN: begin
                    r_k0   <= r_zero ? '0 : w_sk0.val;
                    r_k1   <= r_zero ? '0 : w_sk1.val;
                    r_flag <= r_flag | (!r_zero & (w_sk0.ovf | w_sk1.ovf));
                end
                OP_RATE: begin
                    r_rate <= w_srate.val;
                    r_flag <= r_flag | w_srate.ovf;
                end
                default: r_flag <= r_flag;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_o_angle <= r_angle;
            r_o_rate  <= r_rate;
            r_o_bias  <= r_bias;
            r_o_sat   <= r_flag;
        end
    end

    assign o_angle_out = r_o_angle;
    assign o_rate_out  = r_o_rate;
    assign o_bias_out  = r_o_bias;
    assign o_saturated = r_o_sat;

endmodule

>>> rtl/angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
// two-state kalman filter: angle and gyro bias, signed q16.16 data, q8.24 covariance
// input channel: i_in_valid / o_in_stall carry a request of angle_meas and rate_meas;
// a request is taken at a clock edge with i_in_valid high and o_in_stall low
// output channel: o_out_valid / i_out_stall carry angle_out, rate_out, bias_out and
// saturated; the result is taken at an edge with o_out_valid high, i_out_stall low
// configuration: i_cfg_we writes i_cfg_data to register i_cfg_idx (0 step time,
// 1 angle noise, 2 bias noise, 3 measurement noise); write only while idle
// processing: 12 predict steps, two 56-bit bit-serial restoring gain divisions with a
// shared denominator, 14 correction steps and an output load; one request at a time,
// so o_in_stall stays high until the result is loaded; all products go through the
// shared 32x32 multiplier
// a result waiting on i_out_stall does not block the next request; the block
// holds its last step until the output register is free
// reset clears the filter state (covariance to identity) and restores the
// default register values; o_out_valid drops and o_in_stall goes low
module angle_bias_kalman_filter
    import abkf_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WORD_W-1:0]    i_angle_meas,
    input  logic [WORD_W-1:0]    i_rate_meas,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [WORD_W-1:0]    o_angle_out,
    output logic [WORD_W-1:0]    o_rate_out,
    output logic [WORD_W-1:0]    o_bias_out,
    output logic                 o_saturated,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [CFG_W-1:0]     i_cfg_data
);

    t_cmd  w_cmd;
    t_stat w_stat;

    abkf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    abkf_dp u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_angle_meas (i_angle_meas),
        .i_rate_meas  (i_rate_meas),
        .o_angle_out  (o_angle_out),
        .o_rate_out   (o_rate_out),
        .o_bias_out   (o_bias_out),
        .o_saturated  (o_saturated)
    );

endmodule

>>> rtl/abkf_checker.sv
`timescale 1ns / 1ps
module abkf_checker
    import abkf_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_stall,
    input logic              o_out_valid,
    input logic              i_out_stall,
    input logic [WORD_W-1:0] o_angle_out
);

    // request taken means busy next cycle
    a_busy_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("no stall after request");

    // no result can appear the cycle after a request
    a_no_instant_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall && !(o_out_valid && i_out_stall) |=> !$rose(o_out_valid))
        else $error("result too early");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_out_valid && !o_in_stall)
        else $error("not idle after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_angle_out))
        else $error("stalled result changed");

endmodule

bind angle_bias_kalman_filter abkf_checker u_abkf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_angle_out (o_angle_out)
);

>>> verif/tb_angle_bias_kalman_filter.sv
`timescale 1ns / 1ps
module tb_angle_bias_kalman_filter;
    import abkf_pkg::*;

    typedef struct packed {
        logic [WORD_W-1:0] angle_meas;
        logic [WORD_W-1:0] rate_meas;
    } t_sample;

    typedef struct packed {
        logic [WORD_W-1:0] angle_out;
        logic [WORD_W-1:0] rate_out;
        logic [WORD_W-1:0] bias_out;
        logic              saturated;
    } t_estimate;

    localparam longint SIG_MAX = 64'sd2147483647;
    localparam longint SIG_MIN = -64'sd2147483648;
    localparam int CYCLE_LIMIT = 400000;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_in_valid = 1'b0;
    logic                 o_in_stall;
    logic [WORD_W-1:0]    i_angle_meas = '0;
    logic [WORD_W-1:0]    i_rate_meas = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    logic [WORD_W-1:0]    o_angle_out;
    logic [WORD_W-1:0]    o_rate_out;
    logic [WORD_W-1:0]    o_bias_out;
    logic                 o_saturated;
    logic                 i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx = REG_STEP_TIME;
    logic [CFG_W-1:0]     i_cfg_data = '0;

    angle_bias_kalman_filter i_dut (.*);

    always #2 i_clk = ~i_clk;

    // filter state of the predictor
    longint est_angle, est_bias, p_aa, p_ab, p_ba, p_bb;
    longint cfg_dt, cfg_qa, cfg_qb, cfg_r;

    t_sample   pending_samples[$];
    t_estimate expected_estimates[$];
    int        n_fail = 0;
    longint    cycle_count = 0;
    bit        sim_done = 1'b0;
    int        drv_wait = 0;
    int        mon_wait = 0;
    bit        driving = 1'b0;
    bit        in_acc = 1'b0;

    function automatic longint clamp_word(input longint v, inout bit flag);
        if (v > SIG_MAX) begin
            flag = 1'b1;
            return SIG_MAX;
        end
        if (v < SIG_MIN) begin
            flag = 1'b1;
            return SIG_MIN;
        end
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return (a * b + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic t_estimate filter_step(input t_sample s);
        t_estimate r;
        bit f;
        longint meas, gyro, rate, err, pdot, e, k0, k1, t0, t1;
        f = 1'b0;
        meas = longint'($signed(s.angle_meas));
        gyro = longint'($signed(s.rate_meas));
        rate = clamp_word(gyro - est_bias, f);
        est_angle = clamp_word(est_angle + fix_mul(rate, cfg_dt), f);
        err = clamp_word(meas - est_angle, f);
        pdot = clamp_word(cfg_qa - p_ab - p_ba, f);
        p_aa = clamp_word(p_aa + fix_mul(pdot, cfg_dt), f);
        p_ab = clamp_word(p_ab - fix_mul(p_bb, cfg_dt), f);
        p_ba = clamp_word(p_ba - fix_mul(p_bb, cfg_dt), f);
        p_bb = clamp_word(p_bb + fix_mul(cfg_qb, cfg_dt), f);
        e = cfg_r + p_aa;
        if (e == 0) begin
            k0 = 0;
            k1 = 0;
            f = 1'b1;
        end else begin
            k0 = clamp_word((p_aa * 64'sd16777216) / e, f);
            k1 = clamp_word((p_ba * 64'sd16777216) / e, f);
        end
        t0 = p_aa;
        t1 = p_ab;
        p_aa = clamp_word(p_aa - fix_mul(k0, t0), f);
        p_ab = clamp_word(p_ab - fix_mul(k0, t1), f);
        p_ba = clamp_word(p_ba - fix_mul(k1, t0), f);
        p_bb = clamp_word(p_bb - fix_mul(k1, t1), f);
        est_angle = clamp_word(est_angle + fix_mul(k0, err), f);
        est_bias = clamp_word(est_bias + fix_mul(k1, err), f);
        rate = clamp_word(gyro - est_bias, f);
        r.angle_out = est_angle[31:0];
        r.rate_out = rate[31:0];
        r.bias_out = est_bias[31:0];
        r.saturated = f;
        return r;
    endfunction

    // request taken at the last rising edge
    always @(posedge i_clk) begin
        in_acc <= i_rst_n && i_in_valid && !o_in_stall;
    end

    // driver
    always @(negedge i_clk) begin
        if (i_rst_n) begin
            if (in_acc) begin
                expected_estimates.push_back(filter_step(pending_samples.pop_front()));
                driving = 1'b0;
                drv_wait = $urandom_range(0, 3);
            end
            if (!driving && pending_samples.size() > 0) begin
                if (drv_wait > 0) begin
                    drv_wait--;
                    i_in_valid <= 1'b0;
                end else begin
                    driving = 1'b1;
                    i_in_valid <= 1'b1;
                    i_angle_meas <= pending_samples[0].angle_meas;
                    i_rate_meas <= pending_samples[0].rate_meas;
                end
            end else if (!driving) begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_estimate exp_r;
        cycle_count <= cycle_count + 1;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (expected_estimates.size() == 0) begin
                $error("unexpected result");
                n_fail++;
            end else begin
                exp_r = expected_estimates.pop_front();
                if (o_angle_out !== exp_r.angle_out) begin
                    $error("angle_out exp %h got %h", exp_r.angle_out, o_angle_out);
                    n_fail++;
                end
                if (o_rate_out !== exp_r.rate_out) begin
                    $error("rate_out exp %h got %h", exp_r.rate_out, o_rate_out);
                    n_fail++;
                end
                if (o_bias_out !== exp_r.bias_out) begin
                    $error("bias_out exp %h got %h", exp_r.bias_out, o_bias_out);
                    n_fail++;
                end
                if (o_saturated !== exp_r.saturated) begin
                    $error("saturated exp %b got %b", exp_r.saturated, o_saturated);
                    n_fail++;
                end
            end
            mon_wait = $urandom_range(0, 3);
        end
    end

    always @(negedge i_clk) begin
        if (mon_wait > 0) begin
            i_out_stall <= 1'b1;
            mon_wait--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        if (cycle_count > CYCLE_LIMIT && !sim_done) begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    task automatic add_sample(input logic [31:0] a, input logic [31:0] r);
        t_sample s;
        s.angle_meas = a;
        s.rate_meas = r;
        pending_samples.push_back(s);
    endtask

    task automatic drain();
        while (pending_samples.size() > 0 || driving || expected_estimates.size() > 0)
            @(posedge i_clk);
        repeat (100) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
        @(negedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= idx;
        i_cfg_data <= val;
        case (idx)
            REG_STEP_TIME:   cfg_dt = val;
            REG_ANGLE_NOISE: cfg_qa = val;
            REG_BIAS_NOISE:  cfg_qb = val;
            default:         cfg_r = val;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic random_burst(input int n, input int mode);
        repeat (n) begin
            case (mode)
                0: add_sample($urandom, $urandom);
                default: add_sample($urandom_range(0, 32'h000c_0000) - 32'h0006_0000,
                                    $urandom_range(0, 32'h0040_0000) - 32'h0020_0000);
            endcase
        end
    endtask

    initial begin
        est_angle = 0;
        est_bias = 0;
        p_aa = 16777216;
        p_ab = 0;
        p_ba = 0;
        p_bb = 16777216;
        cfg_dt = RST_STEP_TIME;
        cfg_qa = RST_ANGLE_NOISE;
        cfg_qb = RST_BIAS_NOISE;
        cfg_r = RST_MEAS_NOISE;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: field extremes at reset defaults
        add_sample(32'h0000_0000, 32'h0000_0000);
        add_sample(32'h7fff_ffff, 32'h7fff_ffff);
        add_sample(32'h8000_0000, 32'h8000_0000);
        add_sample(32'h7fff_ffff, 32'h8000_0000);
        add_sample(32'h8000_0000, 32'h7fff_ffff);
        add_sample(32'hffff_ffff, 32'h0000_0001);
        add_sample(32'h0001_0000, 32'hffff_0000);
        random_burst(8, 1);
        drain();

        // zero innovation variance and negative variance
        write_reg(REG_MEAS_NOISE, 31'd0);
        write_reg(REG_STEP_TIME, 31'd0);
        add_sample(32'h0001_0000, 32'h0002_0000);
        drain();
        write_reg(REG_ANGLE_NOISE, 31'h7fff_ffff);
        write_reg(REG_STEP_TIME, 31'h7fff_ffff);
        add_sample(32'h1234_5678, 32'hfedc_ba98);
        add_sample(32'h8000_0000, 32'h7fff_ffff);
        add_sample(32'h0000_0000, 32'h0000_0000);
        drain();

        // phases over several register settings
        write_reg(REG_STEP_TIME, RST_STEP_TIME);
        write_reg(REG_ANGLE_NOISE, RST_ANGLE_NOISE);
        write_reg(REG_BIAS_NOISE, RST_BIAS_NOISE);
        write_reg(REG_MEAS_NOISE, RST_MEAS_NOISE);
        random_burst(200, 1);
        random_burst(40, 0);
        drain();
        write_reg(REG_STEP_TIME, 31'd1);
        write_reg(REG_ANGLE_NOISE, 31'd0);
        write_reg(REG_BIAS_NOISE, 31'd0);
        write_reg(REG_MEAS_NOISE, 31'd1);
        random_burst(100, 1);
        random_burst(20, 0);
        drain();
        write_reg(REG_STEP_TIME, 31'h7fff_ffff);
        write_reg(REG_BIAS_NOISE, 31'h7fff_ffff);
        write_reg(REG_MEAS_NOISE, 31'h7fff_ffff);
        random_burst(60, 0);
        random_burst(40, 1);
        drain();
        write_reg(REG_STEP_TIME, CFG_W'($urandom_range(1, 32'h0100_0000)));
        write_reg(REG_ANGLE_NOISE, CFG_W'($urandom_range(0, 32'h0010_0000)));
        write_reg(REG_BIAS_NOISE, CFG_W'($urandom_range(0, 32'h0010_0000)));
        write_reg(REG_MEAS_NOISE, CFG_W'($urandom_range(1, 32'h0400_0000)));
        random_burst(200, 1);
        random_burst(40, 0);
        drain();

        sim_done = 1'b1;
        if (n_fail == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule
